>>> rtl/tctg_pkg.sv
// ----------------------------------------------------------------------------
// tctg_pkg
// Shared types and constants of the three-channel square tone generator.
// ----------------------------------------------------------------------------
package tctg_pkg;

	// Field widths
	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int TICK_W      = 7;
	localparam int TONE_W      = 12;
	localparam int VOL_W       = 4;
	localparam int PHASE_W     = 5;
	localparam int CNT_W       = 14;
	localparam int SEL_W       = 4;
	localparam int NUM_OUT     = 3;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	// Defaults of the top-level parameters
	localparam int NUM_CHANNELS_DEF = 3;
	localparam int MAX_TICKS_DEF    = 64;

	// Command queue between front and back
	localparam int Q_AW = 1;

	// Bus decode
	localparam logic [ADDR_W-1:0] LATCH_MASK  = 16'hE000;
	localparam logic [ADDR_W-1:0] LATCH_MATCH = 16'hC000;

	// Register map
	localparam logic [SEL_W-1:0] SEL_PERIOD_FIRST = 4'd0;
	localparam logic [SEL_W-1:0] SEL_PERIOD_LAST  = 4'd5;
	localparam logic [SEL_W-1:0] SEL_ENABLE       = 4'd7;
	localparam logic [SEL_W-1:0] SEL_VOL_FIRST    = 4'd8;
	localparam logic [SEL_W-1:0] SEL_VOL_LAST     = 4'd10;

	localparam logic [TONE_W-1:0] PERIOD_RESET = 12'hFFF;
	localparam int                PHASE_ON_BIT = 4;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_LATCH = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [DATA_W-1:0]  data;
		logic [TICK_W-1:0]  ticks;
	} cmd_t;

	typedef struct packed {
		logic               wr_lo;
		logic               wr_hi;
		logic               wr_vol;
		logic               wr_en;
		logic               en_val;
		logic [DATA_W-1:0]  data;
		logic               sub;
		logic [TICK_W-1:0]  ticks;
		logic               reload;
	} lane_ctl_t;

	typedef struct packed {
		logic               need_reload;
		logic [VOL_W-1:0]   level;
	} lane_sts_t;

endpackage

>>> rtl/tctg_front.sv
// ----------------------------------------------------------------------------
// tctg_front
// Accepts input beats, classifies them into latch, data write or tick
// commands, saturates the tick count and holds them in a short queue.
// ----------------------------------------------------------------------------
module tctg_front #(
	parameter int MAX_TICKS = tctg_pkg::MAX_TICKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tctg_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	input  logic                            s_axis_tuser,
	output logic                            q_valid,
	output tctg_pkg::cmd_t                  q_head,
	input  logic                            q_pop
);
	import tctg_pkg::*;

	localparam int Q_DEPTH = 1 << Q_AW;

	cmd_t              mem_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_AW:0]     count_q;
	cmd_t              cmd_in;
	logic [ADDR_W-1:0] addr;
	logic [TICK_W-1:0] raw_ticks;
	logic              push;

	assign addr      = s_axis_tdata[ADDR_W-1:0];
	assign raw_ticks = s_axis_tdata[ADDR_W+DATA_W +: TICK_W];

	always_comb begin
		cmd_in       = '0;
		cmd_in.data  = s_axis_tdata[ADDR_W +: DATA_W];
		cmd_in.ticks = raw_ticks;
		if (int'(raw_ticks) > MAX_TICKS) begin
			cmd_in.ticks = TICK_W'(MAX_TICKS);
		end
		if (s_axis_tuser) begin
			cmd_in.kind = CMD_TICK;
		end else if ((addr & LATCH_MASK) == LATCH_MATCH) begin
			cmd_in.kind = CMD_LATCH;
		end else begin
			cmd_in.kind = CMD_WRITE;
		end
	end

	assign s_axis_tready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign push          = s_axis_tvalid && s_axis_tready;
	assign q_valid       = (count_q != '0);
	assign q_head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + (Q_AW+1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (Q_AW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/tctg_chan.sv
// ----------------------------------------------------------------------------
// tctg_chan
// One tone channel: period, volume and enable registers, the signed
// down-counter and the duty phase. Performs at most one reload per cycle.
// ----------------------------------------------------------------------------
module tctg_chan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tctg_pkg::lane_ctl_t  ctl,
	output tctg_pkg::lane_sts_t  sts
);
	import tctg_pkg::*;

	logic [TONE_W-1:0]       period_q;
	logic [VOL_W-1:0]        volume_q;
	logic                    en_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic [PHASE_W-1:0]      phase_q;
	logic [CNT_W-1:0]        reload_amt;
	logic                    need_reload;

	assign reload_amt  = CNT_W'(period_q) + CNT_W'(1);
	// counter at or below zero
	assign need_reload = en_q && (cnt_q[CNT_W-1] || (cnt_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			volume_q <= '0;
			en_q     <= 1'b0;
			cnt_q    <= CNT_W'(PERIOD_RESET);
			phase_q  <= '0;
		end else begin
			if (ctl.wr_lo) begin
				period_q[DATA_W-1:0] <= ctl.data;
			end
			if (ctl.wr_hi) begin
				period_q[TONE_W-1:DATA_W] <= ctl.data[TONE_W-DATA_W-1:0];
			end
			if (ctl.wr_vol) begin
				volume_q <= ctl.data[VOL_W-1:0];
			end
			if (ctl.wr_en) begin
				en_q <= ctl.en_val;
			end
			if (en_q && ctl.sub) begin
				cnt_q <= cnt_q - $signed(CNT_W'(ctl.ticks));
			end else if (ctl.reload && need_reload) begin
				cnt_q   <= cnt_q + $signed(reload_amt);
				phase_q <= phase_q + PHASE_W'(1);
			end
		end
	end

	assign sts.need_reload = need_reload;
	assign sts.level       = (en_q && phase_q[PHASE_ON_BIT]) ? volume_q : '0;

endmodule

>>> rtl/tctg_back.sv
// ----------------------------------------------------------------------------
// tctg_back
// Pops commands from the queue and carries them out: register select,
// register writes and tick processing over the channel lanes, then places
// the three levels in the output register.
// ----------------------------------------------------------------------------
module tctg_back #(
	parameter int NUM_CHANNELS = tctg_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              q_valid,
	input  tctg_pkg::cmd_t                                    q_head,
	output logic                                              q_pop,
	input  logic                                              out_ready,
	output logic                                              out_valid,
	output logic [tctg_pkg::NUM_OUT-1:0][tctg_pkg::VOL_W-1:0] out_level
);
	import tctg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	state_t                        state_q;
	cmd_t                          cmd_q;
	logic [SEL_W-1:0]              reg_select_q;
	logic                          out_valid_q;
	logic [NUM_OUT-1:0][VOL_W-1:0] out_level_q;

	lane_ctl_t                     lane_ctl [NUM_CHANNELS];
	lane_sts_t                     lane_sts [NUM_CHANNELS];
	logic [NUM_OUT-1:0][VOL_W-1:0] level_now;
	logic                          any_reload;
	logic                          out_free;
	logic                          exec_write;
	logic                          is_period;
	logic                          is_enable;
	logic                          is_volume;

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign out_free   = !out_valid_q || out_ready;
	assign exec_write = (state_q == ST_EXEC) && (cmd_q.kind == CMD_WRITE);

	always_comb begin
		is_period = 1'b0;
		is_enable = 1'b0;
		is_volume = 1'b0;
		case (reg_select_q) inside
			[SEL_PERIOD_FIRST:SEL_PERIOD_LAST]: is_period = 1'b1;
			SEL_ENABLE:                         is_enable = 1'b1;
			[SEL_VOL_FIRST:SEL_VOL_LAST]:       is_volume = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		any_reload = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			any_reload = any_reload | lane_sts[i].need_reload;
		end
	end

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		always_comb begin
			lane_ctl[i]        = '0;
			lane_ctl[i].data   = cmd_q.data;
			lane_ctl[i].ticks  = cmd_q.ticks;
			// enables are active low in the register
			lane_ctl[i].en_val = !cmd_q.data[i];
			lane_ctl[i].wr_lo  = exec_write && is_period &&
				(reg_select_q[SEL_W-1:1] == 3'(i)) && !reg_select_q[0];
			lane_ctl[i].wr_hi  = exec_write && is_period &&
				(reg_select_q[SEL_W-1:1] == 3'(i)) && reg_select_q[0];
			lane_ctl[i].wr_vol = exec_write && is_volume &&
				(reg_select_q[2:0] == 3'(i));
			lane_ctl[i].wr_en  = exec_write && is_enable;
			lane_ctl[i].sub    = (state_q == ST_EXEC) && (cmd_q.kind == CMD_TICK) &&
				(cmd_q.ticks != '0);
			lane_ctl[i].reload = (state_q == ST_RUN);
		end

		tctg_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[i]),
			.sts    (lane_sts[i])
		);
	end

	for (genvar k = 0; k < NUM_OUT; k++) begin : g_level
		if (k < NUM_CHANNELS) begin : g_used
			assign level_now[k] = lane_sts[k].level;
		end else begin : g_unused
			assign level_now[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if ((state_q == ST_RUN) && !any_reload && out_free) begin
			out_level_q <= level_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			reg_select_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_RUN) && !any_reload && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q.kind == CMD_LATCH) begin
						reg_select_q <= cmd_q.data[SEL_W-1:0];
					end
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// reload lanes until no enabled counter is at or below zero, then publish
					if (!any_reload && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_level = out_level_q;

endmodule

>>> rtl/three_channel_square_tone_generator_unit.sv
// ----------------------------------------------------------------------------
// three_channel_square_tone_generator_unit
// Three-channel square tone generator behind an address latch and data port.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one beat is either a bus write (tuser = 0) or a
// tick of elapsed clocks (tuser = 1). A write to 0xC000-0xDFFF latches the
// register select, any other address writes the selected register.
// Output stream (m_axis): one beat per input beat with the three channel
// levels after that item, in input order.
// An input beat passes the command queue, the command register and the
// execute and run states before its levels reach the output register;
// in the run state each cycle performs one reload in every channel that
// needs it, up to the tick count per channel with period zero. A new item
// starts only after the last is published; the reload loop sets the pace.
// A two-entry command queue sits between the decoder and the execution
// unit, so input beats are still taken while a result waits at the output.
// When the receiver stalls, the result holds in the output register and
// the queue fills; s_axis_tready drops once it is full.
// Reset: periods and counters to 0xFFF, volumes, phases, enables and the
// register select to zero; queue and output emptied.
// ----------------------------------------------------------------------------
module three_channel_square_tone_generator_unit #(
	parameter int NUM_CHANNELS = tctg_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_TICKS    = tctg_pkg::MAX_TICKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// bus_addr[15:0], bus_data[23:16], tick_count[30:24], zero[31]
	input  logic [tctg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// func[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// level_a[3:0], level_b[7:4], level_c[11:8], zero[15:12]
	output logic [tctg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tctg_pkg::*;

	logic                          q_valid;
	cmd_t                          q_head;
	logic                          q_pop;
	logic [NUM_OUT-1:0][VOL_W-1:0] out_level;

	tctg_front #(
		.MAX_TICKS (MAX_TICKS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop)
	);

	tctg_back #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_level (out_level)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - NUM_OUT*VOL_W)'(0), out_level};

endmodule

>>> rtl/tctg_chk.sv
// ----------------------------------------------------------------------------
// tctg_chk
// Port-level checks of the tone generator, bound to the top level.
// ----------------------------------------------------------------------------
module tctg_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [tctg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input logic                             s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tctg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tctg_pkg::*;

	// queue, command register and output register
	localparam int MAX_OUTSTANDING = (1 << Q_AW) + 2;

	logic       in_acc;
	logic       out_acc;
	logic [2:0] outstanding_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output beat changed");

	a_no_extra_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> outstanding_q != '0)
		else $error("output beat without an accepted input beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 3'(MAX_OUTSTANDING))
		else $error("more items in flight than the block can hold");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && outstanding_q == '0 |=> !m_axis_tvalid)
		else $error("result appeared one cycle after its input beat");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:NUM_OUT*VOL_W] == '0)
		else $error("padding bits of output beat not zero");

endmodule

bind three_channel_square_tone_generator_unit tctg_chk u_tctg_chk (.*);
